// File: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, status codes and the alphabet lookup shared by the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LENGTH   = 3'd1;
    localparam logic [2:0] ST_BADCHAR  = 3'd2;
    localparam logic [2:0] ST_PADS     = 3'd3;
    localparam logic [2:0] ST_AFTERPAD = 3'd4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] in_char;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_of_run;
        logic       end_of_message;
        logic [2:0] status;
    } t_result;

    // one front decision: up to three result beats
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nres;
        logic            has_byte;
        logic            eom;
        logic [2:0]      status;
    } t_job;

    // returns {valid, sextet}; sextet is zero outside the alphabet
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

// File: rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Classifies characters, tracks quad position, pads and the first error,
// and hands a job to the queue whenever a character causes results.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  b64d_pkg::t_in_item i_item,
    output logic              o_job_valid,
    output b64d_pkg::t_job    o_job
);

    logic [17:0] r_buf, n_buf;
    logic [1:0]  r_pos, n_pos;
    logic [1:0]  r_pad, n_pad;
    logic [2:0]  r_err, n_err;

    logic       is_pad;
    logic [6:0] mapped;
    logic [5:0] sx;
    logic       quad_end;
    logic [1:0] nbytes;
    logic [5:0] c0, c1, c2;

    always_comb begin
        is_pad = (i_item.in_char == b64d_pkg::PAD_CHAR);
        mapped = b64d_pkg::map_char(i_item.in_char);
        n_pad  = (is_pad && r_pad != 2'd3) ? r_pad + 2'd1 : r_pad;
        n_err  = r_err;
        if (r_err == b64d_pkg::ST_OK) begin
            if (is_pad) begin
                if (n_pad == 2'd3) begin
                    n_err = b64d_pkg::ST_PADS;
                end
            end else if (r_pad != 2'd0) begin
                n_err = b64d_pkg::ST_AFTERPAD;
            end else if (!mapped[6]) begin
                n_err = b64d_pkg::ST_BADCHAR;
            end
        end
        sx       = (is_pad || r_pad != 2'd0) ? 6'd0 : mapped[5:0];
        quad_end = (r_pos == 2'd3);
        c0 = r_buf[17:12];
        c1 = r_buf[11:6];
        c2 = r_buf[5:0];
        nbytes = (quad_end && n_err == b64d_pkg::ST_OK && n_pad != 2'd3)
               ? 2'd3 - n_pad : 2'd0;

        o_job.bytes[0] = {c0, c1[5:4]};
        o_job.bytes[1] = {c1[3:0], c2[5:2]};
        o_job.bytes[2] = {c2[1:0], sx};
        o_job.has_byte = (nbytes != 2'd0);
        o_job.nres     = (nbytes == 2'd0) ? 2'd1 : nbytes;
        o_job.eom      = i_item.last_char;
        o_job.status   = !i_item.last_char ? b64d_pkg::ST_OK
                       : (quad_end ? n_err : b64d_pkg::ST_LENGTH);
        o_job_valid    = i_valid && (i_item.last_char || nbytes != 2'd0);

        if (i_item.last_char) begin
            n_buf = 18'd0;
            n_pos = 2'd0;
        end else if (quad_end) begin
            n_buf = 18'd0;
            n_pos = 2'd0;
        end else begin
            n_buf = {r_buf[11:0], sx};
            n_pos = r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= 18'd0;
            r_pos <= 2'd0;
            r_pad <= 2'd0;
            r_err <= b64d_pkg::ST_OK;
        end else if (i_valid) begin
            r_buf <= n_buf;
            r_pos <= n_pos;
            r_pad <= i_item.last_char ? 2'd0 : n_pad;
            r_err <= i_item.last_char ? b64d_pkg::ST_OK : n_err;
        end
    end

endmodule

// File: rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output b64d_pkg::t_job o_job,
    input  logic           i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64d_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// File: rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Holds one job and plays it out as result beats, one per cycle while i_pop is high.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  b64d_pkg::t_job  i_job,
    output logic            o_take,
    output logic            o_empty,
    output b64d_pkg::t_result o_result,
    input  logic            i_pop
);

    b64d_pkg::t_job r_job;
    logic           r_busy;
    logic [1:0]     r_idx;
    logic           fin;

    always_comb begin
        fin    = (r_idx == r_job.nres - 2'd1);
        o_take = i_valid && (!r_busy || (i_pop && fin));
        o_empty = !r_busy;
        o_result.data_byte      = r_job.has_byte ? r_job.bytes[r_idx] : 8'd0;
        o_result.has_byte       = r_job.has_byte;
        o_result.last_of_run    = fin;
        o_result.end_of_message = fin && r_job.eom;
        o_result.status         = fin ? r_job.status : b64d_pkg::ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (i_pop && r_busy) begin
            if (fin) begin
                r_busy <= 1'b0;
                r_idx  <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// File: rtl/base64_decoder_core.sv
// ----------------------------------------------------------------------------
// base64_decoder_core
// Streaming base64 decoder, one character per beat in, one result per beat
// out.
// ----------------------------------------------------------------------------
// A character is taken every cycle while full is low; the front decides its
// results in the same cycle. Each fourth character of a quad yields up to
// three byte beats and the last character of a message yields the closing
// status beat, so output runs at one beat per cycle while pop is high and a
// job queue of QUEUE_DEPTH entries absorbs the three-beat bursts. Sustained
// input rate is one character per cycle on valid base64 text; full rises only
// when the consumer stalls. Each job passes the queue and the back's job register.
module base64_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  b64d_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output b64d_pkg::t_result   o_result
);

    logic           accept;
    logic           job_valid;
    b64d_pkg::t_job job_in;
    logic           q_valid;
    b64d_pkg::t_job q_job;
    logic           take;
    logic           q_full;

    assign full   = q_full;
    assign accept = push && !q_full;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_item      (i_in_item),
        .o_job_valid (job_valid),
        .o_job       (job_in)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (take)
    );

    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (q_job),
        .o_take   (take),
        .o_empty  (empty),
        .o_result (o_result),
        .i_pop    (pop)
    );

endmodule
